FILE: rtl/tcara_pkg.sv
// ============================================================================
// tcara_pkg
// Shared types and constants for the two-class alternating resource arbiter.
// ============================================================================
`default_nettype none

package tcara_pkg;

    // Default number of waiting entries per category
    localparam int QUEUE_DEPTH_DEF = 16;

    // Requester id width
    localparam int ID_W = 8;

    // Opcodes of an input transaction
    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Result codes
    typedef enum logic [2:0] {
        OUT_GRANTED        = 3'd0,
        OUT_QUEUED         = 3'd1,
        OUT_REL_IDLE       = 3'd2,
        OUT_REL_HANDOVER   = 3'd3,
        OUT_FULL           = 3'd4,
        OUT_REL_WHILE_IDLE = 3'd5
    } t_outcome;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;   // capture the accepted request
        logic exec;   // evaluate the captured request, update state and result
    } t_dp_cmd;

endpackage

`default_nettype wire

FILE: rtl/tcara_if.sv
// ============================================================================
// tcara_req_if / tcara_rsp_if
// Valid/ready channels for requests into and results out of the arbiter.
// ============================================================================
`default_nettype none

interface tcara_req_if;
    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic                       category;
    logic [tcara_pkg::ID_W-1:0] requester_id;

    modport source (output valid, output opcode, output category,
                    output requester_id, input ready);
    modport sink   (input valid, input opcode, input category,
                    input requester_id, output ready);
endinterface

interface tcara_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [2:0]                 outcome;
    logic                       grant_valid;
    logic [tcara_pkg::ID_W-1:0] granted_id;
    logic                       granted_category;

    modport source (output valid, output outcome, output grant_valid,
                    output granted_id, output granted_category, input ready);
    modport sink   (input valid, input outcome, input grant_valid,
                    input granted_id, input granted_category, output ready);
endinterface

`default_nettype wire

FILE: rtl/two_class_alternating_resource_arbiter.sv
// ============================================================================
// two_class_alternating_resource_arbiter
// Lock arbiter for one resource shared by two requester categories.
// ============================================================================
// Each request transaction (acquire or release) produces exactly one result
// transaction. An acquire is granted at once when the resource is free,
// otherwise it waits in its category's FIFO (QUEUE_DEPTH entries) or is
// rejected when that FIFO is full. A release hands the resource to the head
// of the other category's FIFO first, then to the holder's own category, and
// frees it when both are empty. A transaction is accepted in S_IDLE and
// executed in S_EXEC against the registered head read of the FIFO
// memories; no new request is accepted in S_EXEC, and the result register
// lets the next request be accepted in the cycle its result is taken.
// The FIFO memories need no clearing after reset.
`default_nettype none

module two_class_alternating_resource_arbiter #(
    parameter int QUEUE_DEPTH = tcara_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tcara_req_if.sink   i_req,
    tcara_rsp_if.source o_rsp
);
    import tcara_pkg::*;

    t_dp_cmd cmd;

    tcara_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    tcara_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_opcode           (i_req.opcode),
        .i_category         (i_req.category),
        .i_requester_id     (i_req.requester_id),
        .o_outcome          (o_rsp.outcome),
        .o_grant_valid      (o_rsp.grant_valid),
        .o_granted_id       (o_rsp.granted_id),
        .o_granted_category (o_rsp.granted_category)
    );

endmodule

`default_nettype wire

FILE: rtl/tcara_ctrl.sv
// ============================================================================
// tcara_ctrl
// Controller: sequences accept and execute, owns the result valid flag.
// ============================================================================
`default_nettype none

module tcara_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output      logic               o_in_ready,
    output      logic               o_out_valid,
    input  wire logic               i_out_ready,
    output      tcara_pkg::t_dp_cmd o_cmd
);
    import tcara_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   accept;

    // Take a new transaction only when idle and the result slot frees up
    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    assign o_cmd.load = accept;
    assign o_cmd.exec = (r_state == S_EXEC);

    // State and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (r_out_valid && i_out_ready) begin
                        r_out_valid <= 1'b0;
                    end
                    if (accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tcara_dp.sv
// ============================================================================
// tcara_dp
// Datapath: holder state, two per-category FIFOs and the result register.
// ============================================================================
`default_nettype none

module tcara_dp #(
    parameter int QUEUE_DEPTH = tcara_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire tcara_pkg::t_dp_cmd         i_cmd,
    input  wire logic                       i_opcode,
    input  wire logic                       i_category,
    input  wire logic [tcara_pkg::ID_W-1:0] i_requester_id,
    output      logic [2:0]                 o_outcome,
    output      logic                       o_grant_valid,
    output      logic [tcara_pkg::ID_W-1:0] o_granted_id,
    output      logic                       o_granted_category
);
    import tcara_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = IDX_W + 1;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

    // Captured request
    logic            r_op;
    logic            r_cat;
    logic [ID_W-1:0] r_id;

    // Holder state
    logic r_busy, n_busy;
    logic r_owner, n_owner;

    // FIFO pointers
    logic [IDX_W-1:0] r_head0, n_head0, r_head1, n_head1;
    logic [CNT_W-1:0] r_cnt0, n_cnt0, r_cnt1, n_cnt1;

    // FIFO storage and registered head reads
    logic [ID_W-1:0] r_mem0 [QUEUE_DEPTH];
    logic [ID_W-1:0] r_mem1 [QUEUE_DEPTH];
    logic [ID_W-1:0] r_rd0, r_rd1;

    // Result register
    logic [2:0]      r_outcome;
    logic            r_gv;
    logic [ID_W-1:0] r_gid;
    logic            r_gcat;

    t_outcome         n_outcome;
    logic             n_gv;
    logic [ID_W-1:0]  n_gid;
    logic             n_gcat;
    logic             wr0, wr1, pop0, pop1;
    logic [IDX_W-1:0] head_sel, wr_addr;
    logic [CNT_W-1:0] cnt_sel;
    logic [SUM_W-1:0] wr_sum;
    logic             other_ne, same_ne, pop_cls;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
        idx_inc = (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    // Tail address of the requested category, wrapped at the depth
    always_comb begin
        head_sel = r_cat ? r_head1 : r_head0;
        cnt_sel  = r_cat ? r_cnt1  : r_cnt0;
        wr_sum   = SUM_W'(head_sel) + SUM_W'(cnt_sel);
        wr_addr  = (wr_sum >= DEPTH_S) ? IDX_W'(wr_sum - DEPTH_S) : IDX_W'(wr_sum);
    end

    // Decision for the captured request
    always_comb begin
        other_ne  = r_owner ? (r_cnt0 != '0) : (r_cnt1 != '0);
        same_ne   = r_owner ? (r_cnt1 != '0) : (r_cnt0 != '0);
        pop_cls   = other_ne ? ~r_owner : r_owner;
        n_busy    = r_busy;
        n_owner   = r_owner;
        n_outcome = OUT_GRANTED;
        n_gv      = 1'b0;
        n_gid     = '0;
        n_gcat    = 1'b0;
        wr0       = 1'b0;
        wr1       = 1'b0;
        pop0      = 1'b0;
        pop1      = 1'b0;
        if (r_op == OP_ACQUIRE) begin
            if (!r_busy) begin
                n_busy    = 1'b1;
                n_owner   = r_cat;
                n_outcome = OUT_GRANTED;
                n_gv      = 1'b1;
                n_gid     = r_id;
                n_gcat    = r_cat;
            end else if (cnt_sel == FULL_CNT) begin
                n_outcome = OUT_FULL;
            end else begin
                n_outcome = OUT_QUEUED;
                wr0       = ~r_cat;
                wr1       = r_cat;
            end
        end else begin
            if (!r_busy) begin
                n_outcome = OUT_REL_WHILE_IDLE;
            end else if (other_ne || same_ne) begin
                // Other category first, then the holder's own
                n_owner   = pop_cls;
                n_outcome = OUT_REL_HANDOVER;
                n_gv      = 1'b1;
                n_gid     = pop_cls ? r_rd1 : r_rd0;
                n_gcat    = pop_cls;
                pop0      = ~pop_cls;
                pop1      = pop_cls;
            end else begin
                n_busy    = 1'b0;
                n_outcome = OUT_REL_IDLE;
            end
        end
    end

    // Pointer updates
    always_comb begin
        n_head0 = pop0 ? idx_inc(r_head0) : r_head0;
        n_head1 = pop1 ? idx_inc(r_head1) : r_head1;
        n_cnt0  = pop0 ? r_cnt0 - 1'b1 : (wr0 ? r_cnt0 + 1'b1 : r_cnt0);
        n_cnt1  = pop1 ? r_cnt1 - 1'b1 : (wr1 ? r_cnt1 + 1'b1 : r_cnt1);
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_opcode;
            r_cat <= i_category;
            r_id  <= i_requester_id;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_owner <= 1'b0;
            r_head0 <= '0;
            r_head1 <= '0;
            r_cnt0  <= '0;
            r_cnt1  <= '0;
        end else if (i_cmd.exec) begin
            r_busy  <= n_busy;
            r_owner <= n_owner;
            r_head0 <= n_head0;
            r_head1 <= n_head1;
            r_cnt0  <= n_cnt0;
            r_cnt1  <= n_cnt1;
        end
    end

    // FIFO memories: one write port, one registered read at the head
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr0) begin
            r_mem0[wr_addr] <= r_id;
        end
        r_rd0 <= r_mem0[r_head0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr1) begin
            r_mem1[wr_addr] <= r_id;
        end
        r_rd1 <= r_mem1[r_head1];
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_outcome <= n_outcome;
            r_gv      <= n_gv;
            r_gid     <= n_gid;
            r_gcat    <= n_gcat;
        end
    end

    assign o_outcome          = r_outcome;
    assign o_grant_valid      = r_gv;
    assign o_granted_id       = r_gid;
    assign o_granted_category = r_gcat;

endmodule

`default_nettype wire

FILE: rtl/tcara_checker.sv
// ============================================================================
// tcara_checker
// Port-level checks for the arbiter, bound to the top level.
// ============================================================================
`default_nettype none

module tcara_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_req_valid,
    input wire logic                       i_req_ready,
    input wire logic                       i_rsp_valid,
    input wire logic                       i_rsp_ready,
    input wire logic [2:0]                 i_rsp_outcome,
    input wire logic                       i_rsp_grant_valid,
    input wire logic [tcara_pkg::ID_W-1:0] i_rsp_granted_id,
    input wire logic                       i_rsp_granted_category
);
    import tcara_pkg::*;

    logic req_acc;
    logic is_grant_code;

    assign req_acc       = i_req_valid && i_req_ready;
    assign is_grant_code = (i_rsp_outcome == OUT_GRANTED) ||
                           (i_rsp_outcome == OUT_REL_HANDOVER);

    // Every accepted request is later followed by its valid result
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |-> ##2 i_rsp_valid)
        else $error("result missing after accepted request");

    // Grant flag matches the outcome code
    a_grant_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_grant_valid == is_grant_code))
        else $error("grant flag disagrees with outcome");

    // No grant carries zero id and category
    a_no_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_grant_valid) |->
            (i_rsp_granted_id == '0 && i_rsp_granted_category == 1'b0))
        else $error("non-grant result carries an id");

    // Only defined outcome codes appear
    a_outcome_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_outcome <= OUT_REL_WHILE_IDLE))
        else $error("undefined outcome code");

    // A stalled result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_outcome) && $stable(i_rsp_granted_id)))
        else $error("stalled result changed");

endmodule

bind two_class_alternating_resource_arbiter tcara_checker u_tcara_checker (
    .i_clk                  (i_clk),
    .i_rst_n                (i_rst_n),
    .i_req_valid            (i_req.valid),
    .i_req_ready            (i_req.ready),
    .i_rsp_valid            (o_rsp.valid),
    .i_rsp_ready            (o_rsp.ready),
    .i_rsp_outcome          (o_rsp.outcome),
    .i_rsp_grant_valid      (o_rsp.grant_valid),
    .i_rsp_granted_id       (o_rsp.granted_id),
    .i_rsp_granted_category (o_rsp.granted_category)
);

`default_nettype wire
